// ===== hdl/cau_pkg.sv =====
// cau_pkg: request and result types, operation and status codes, pipeline control word
// shared by every file of the complex arithmetic unit; depends on nothing
package cau_pkg;

    localparam int FIELD_W = 32;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_CONJ = 3'd4;
    localparam logic [2:0] OP_CMP  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]                operation;
        logic signed [FIELD_W-1:0] a_real;
        logic signed [FIELD_W-1:0] a_imag;
        logic signed [FIELD_W-1:0] b_real;
        logic signed [FIELD_W-1:0] b_imag;
    } cau_req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] res_real;
        logic signed [FIELD_W-1:0] res_imag;
        logic                      is_equal;
        logic [1:0]                status;
    } cau_res_t;

    // control word that rides along the divider stages
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic       dz;
        logic       neg_re;
        logic       neg_im;
        logic       big_re;
        logic       big_im;
        logic       eq;
        logic       ovf;
    } cau_ctl_t;

endpackage

// ===== hdl/complex_arithmetic_unit_core.sv =====
// throughput: one request every cycle, busy is never raised
// the divider makes up most of the pipeline, one quotient bit per stage for each of the two parts
// reset: rst_n clears every valid bit at once, results in flight are dropped
// done marks a result for exactly one cycle, the receiver cannot stall it
// depends on cau_pkg, cau_front and cau_div_stage
module complex_arithmetic_unit_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cau_pkg::cau_req_t request,
    output logic              done,
    output cau_pkg::cau_res_t result
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int NW = 2*W + FRAC_BITS;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]   LIMW = (W+1)'(1) << (W-1);

    // pipeline never holds off a request
    assign busy = 1'b0;

    // signals between stages, index k is the input of divider step k
    cau_ctl_t       ctl_s  [0:W];
    logic [2*W-1:0] den_s  [0:W];
    logic [NW-1:0]  rre_s  [0:W];
    logic [NW-1:0]  rim_s  [0:W];
    logic [W-1:0]   qre_s  [0:W];
    logic [W-1:0]   qim_s  [0:W];
    logic [W-1:0]   pre_s  [0:W];
    logic [W-1:0]   pim_s  [0:W];

    // operand register, products, sums and divider setup
    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (start & ~busy),
        .req        (request),
        .ctl_out    (ctl_s[0]),
        .den_out    (den_s[0]),
        .num_re_out (rre_s[0]),
        .num_im_out (rim_s[0]),
        .pre_re_out (pre_s[0]),
        .pre_im_out (pim_s[0])
    );

    assign qre_s[0] = '0;
    assign qim_s[0] = '0;

    // restoring divider, most significant quotient bit first; non-divide
    // results ride along so order is kept for every operation
    for (genvar k = 0; k < W; k++)
    begin : g_div
        cau_div_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .SHIFT      (W - 1 - k)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl_in     (ctl_s[k]),
            .den_in     (den_s[k]),
            .rem_re_in  (rre_s[k]),
            .rem_im_in  (rim_s[k]),
            .q_re_in    (qre_s[k]),
            .q_im_in    (qim_s[k]),
            .pre_re_in  (pre_s[k]),
            .pre_im_in  (pim_s[k]),
            .ctl_out    (ctl_s[k+1]),
            .den_out    (den_s[k+1]),
            .rem_re_out (rre_s[k+1]),
            .rem_im_out (rim_s[k+1]),
            .q_re_out   (qre_s[k+1]),
            .q_im_out   (qim_s[k+1]),
            .pre_re_out (pre_s[k+1]),
            .pre_im_out (pim_s[k+1])
        );
    end

    // clamp of a quotient given its sign; a quotient past W bits always saturates
    function automatic logic [W:0] clampd(input logic neg, input logic big,
                                          input logic [W-1:0] q);
        logic         o;
        logic [W-1:0] nq;
        nq = ~q + 1'b1;
        if (neg)
        begin
            o = big | ({1'b0, q} > LIMW);
            clampd = {o, (o ? MINV : nq)};
        end
        else
        begin
            o = big | q[W-1];
            clampd = {o, (o ? MAXV : q)};
        end
    endfunction

    cau_ctl_t   ctl_f;
    logic [W:0] cd_re, cd_im;
    logic [W-1:0] fin_re, fin_im;
    cau_res_t   result_next;

    assign ctl_f = ctl_s[W];
    assign cd_re = clampd(ctl_f.neg_re, ctl_f.big_re, qre_s[W]);
    assign cd_im = clampd(ctl_f.neg_im, ctl_f.big_im, qim_s[W]);

    // final selection: divide by zero wins, then overflow from any part
    always_comb
    begin
        fin_re               = pre_s[W];
        fin_im               = pim_s[W];
        result_next.is_equal = ctl_f.eq;
        result_next.status   = ctl_f.ovf ? ST_OVF : ST_OK;
        if (ctl_f.op == OP_DIV)
        begin
            if (ctl_f.dz)
            begin
                fin_re             = '0;
                fin_im             = '0;
                result_next.status = ST_DIVZ;
            end
            else
            begin
                fin_re             = cd_re[W-1:0];
                fin_im             = cd_im[W-1:0];
                result_next.status = (cd_re[W] | cd_im[W]) ? ST_OVF : ST_OK;
            end
        end
        result_next.res_real = FIELD_W'($signed(fin_re));
        result_next.res_imag = FIELD_W'($signed(fin_im));
    end

    // output register
    logic     done_reg;
    cau_res_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_f.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/cau_front.sv =====
// cau_front: operand register, short operations, multipliers, product sums and sign/magnitude split
// depends on cau_pkg
module cau_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  cau_pkg::cau_req_t                   req,
    output cau_pkg::cau_ctl_t                   ctl_out,
    output logic [2*DATA_WIDTH-1:0]             den_out,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0]   num_re_out,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0]   num_im_out,
    output logic [DATA_WIDTH-1:0]               pre_re_out,
    output logic [DATA_WIDTH-1:0]               pre_im_out
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2*W + F;
    localparam int DW = 3*W + F + 1;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W:0] LIM  = (2*W+1)'(1) << (W-1);

    function automatic logic [W:0] sat1(input logic [W:0] s);
        logic o;
        o = s[W] ^ s[W-1];
        sat1 = o ? {1'b1, (s[W] ? MINV : MAXV)} : {1'b0, s[W-1:0]};
    endfunction

    // returns {overflow, value} for a product sum given as sign and magnitude
    function automatic logic [W:0] clampm(input logic neg, input logic [2*W:0] mag);
        logic [2*W:0] m;
        logic [2*W:0] nm;
        m  = mag >> F;
        nm = ~m + 1'b1;
        if (neg)
            clampm = (m > LIM) ? {1'b1, MINV} : {1'b0, nm[W-1:0]};
        else
            clampm = (m > LIM - 1'b1) ? {1'b1, MAXV} : {1'b0, m[W-1:0]};
    endfunction

    // stage 0: operand register
    logic                v0_reg;
    logic [2:0]          op0_reg;
    logic signed [W-1:0] ar0_reg, ai0_reg, br0_reg, bi0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        op0_reg <= req.operation;
        ar0_reg <= req.a_real[W-1:0];
        ai0_reg <= req.a_imag[W-1:0];
        br0_reg <= req.b_real[W-1:0];
        bi0_reg <= req.b_imag[W-1:0];
    end

    // stage 1: products and the short operations
    logic signed [W:0] add_re, add_im, sub_re, sub_im, neg_ai;
    logic [W:0]        s_re, s_im;
    logic [W-1:0]      pre_re_next, pre_im_next;
    logic              ovf1_next, eq1_next;

    assign add_re = (W+1)'(ar0_reg) + (W+1)'(br0_reg);
    assign add_im = (W+1)'(ai0_reg) + (W+1)'(bi0_reg);
    assign sub_re = (W+1)'(ar0_reg) - (W+1)'(br0_reg);
    assign sub_im = (W+1)'(ai0_reg) - (W+1)'(bi0_reg);
    assign neg_ai = -((W+1)'(ai0_reg));

    always_comb
    begin
        pre_re_next = '0;
        pre_im_next = '0;
        ovf1_next   = 1'b0;
        eq1_next    = 1'b0;
        s_re        = '0;
        s_im        = '0;
        case (op0_reg)
            OP_ADD:
            begin
                s_re        = sat1(add_re);
                s_im        = sat1(add_im);
                pre_re_next = s_re[W-1:0];
                pre_im_next = s_im[W-1:0];
                ovf1_next   = s_re[W] | s_im[W];
            end
            OP_SUB:
            begin
                s_re        = sat1(sub_re);
                s_im        = sat1(sub_im);
                pre_re_next = s_re[W-1:0];
                pre_im_next = s_im[W-1:0];
                ovf1_next   = s_re[W] | s_im[W];
            end
            OP_CONJ:
            begin
                s_im        = sat1(neg_ai);
                pre_re_next = ar0_reg;
                pre_im_next = s_im[W-1:0];
                ovf1_next   = s_im[W];
            end
            OP_CMP:
                eq1_next = (ar0_reg == br0_reg) && (ai0_reg == bi0_reg);
            default: ;
        endcase
    end

    logic                  v1_reg, ovf1_reg, eq1_reg;
    logic [2:0]            op1_reg;
    logic [W-1:0]          pre_re1_reg, pre_im1_reg;
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_br_reg, p_bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        op1_reg     <= op0_reg;
        ovf1_reg    <= ovf1_next;
        eq1_reg     <= eq1_next;
        pre_re1_reg <= pre_re_next;
        pre_im1_reg <= pre_im_next;
        p_rr_reg    <= ar0_reg * br0_reg;
        p_ii_reg    <= ai0_reg * bi0_reg;
        p_ir_reg    <= ai0_reg * br0_reg;
        p_ri_reg    <= ar0_reg * bi0_reg;
        p_br_reg    <= br0_reg * br0_reg;
        p_bi_reg    <= bi0_reg * bi0_reg;
    end

    // stage 2: sums of products and the divisor |b|^2
    logic signed [2*W:0] sum_re_next, sum_im_next;
    logic [2*W-1:0]      den_next;

    always_comb
    begin
        if (op1_reg == OP_MUL)
        begin
            sum_re_next = (2*W+1)'(p_rr_reg) - (2*W+1)'(p_ii_reg);
            sum_im_next = (2*W+1)'(p_ir_reg) + (2*W+1)'(p_ri_reg);
        end
        else
        begin
            sum_re_next = (2*W+1)'(p_rr_reg) + (2*W+1)'(p_ii_reg);
            sum_im_next = (2*W+1)'(p_ir_reg) - (2*W+1)'(p_ri_reg);
        end
        den_next = $unsigned(p_br_reg) + $unsigned(p_bi_reg);
    end

    logic                v2_reg, ovf2_reg, eq2_reg;
    logic [2:0]          op2_reg;
    logic [W-1:0]        pre_re2_reg, pre_im2_reg;
    logic signed [2*W:0] sum_re2_reg, sum_im2_reg;
    logic [2*W-1:0]      den2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        op2_reg     <= op1_reg;
        ovf2_reg    <= ovf1_reg;
        eq2_reg     <= eq1_reg;
        pre_re2_reg <= pre_re1_reg;
        pre_im2_reg <= pre_im1_reg;
        sum_re2_reg <= sum_re_next;
        sum_im2_reg <= sum_im_next;
        den2_reg    <= den_next;
    end

    // stage 3: sign/magnitude, multiply clamp, divider setup
    logic         neg_re, neg_im;
    logic [2*W:0] mag_re, mag_im;
    logic [W:0]   cm_re, cm_im;
    logic [NW-1:0] num_re, num_im;
    logic [DW-1:0] den_top;
    logic          big_re, big_im;
    cau_ctl_t      ctl_next;
    logic [W-1:0]  pre_re3_next, pre_im3_next;

    assign neg_re  = sum_re2_reg[2*W];
    assign neg_im  = sum_im2_reg[2*W];
    assign mag_re  = neg_re ? $unsigned(-sum_re2_reg) : $unsigned(sum_re2_reg);
    assign mag_im  = neg_im ? $unsigned(-sum_im2_reg) : $unsigned(sum_im2_reg);
    assign cm_re   = clampm(neg_re, mag_re);
    assign cm_im   = clampm(neg_im, mag_im);
    assign num_re  = NW'(mag_re[2*W-1:0]) << F;
    assign num_im  = NW'(mag_im[2*W-1:0]) << F;
    assign den_top = DW'(den2_reg) << W;
    assign big_re  = DW'(num_re) >= den_top;
    assign big_im  = DW'(num_im) >= den_top;

    always_comb
    begin
        ctl_next.valid  = v2_reg;
        ctl_next.op     = op2_reg;
        ctl_next.dz     = (den2_reg == '0);
        ctl_next.neg_re = neg_re;
        ctl_next.neg_im = neg_im;
        ctl_next.big_re = big_re;
        ctl_next.big_im = big_im;
        ctl_next.eq     = eq2_reg;
        ctl_next.ovf    = ovf2_reg;
        pre_re3_next    = pre_re2_reg;
        pre_im3_next    = pre_im2_reg;
        if (op2_reg == OP_MUL)
        begin
            pre_re3_next = cm_re[W-1:0];
            pre_im3_next = cm_im[W-1:0];
            ctl_next.ovf = cm_re[W] | cm_im[W];
        end
    end

    cau_ctl_t ctl3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl3_reg <= '0;
        else
            ctl3_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        den_out    <= den2_reg;
        num_re_out <= num_re;
        num_im_out <= num_im;
        pre_re_out <= pre_re3_next;
        pre_im_out <= pre_im3_next;
    end

    assign ctl_out = ctl3_reg;

endmodule

// ===== hdl/cau_div_stage.sv =====
// cau_div_stage: one restoring-division step for the real and imaginary quotients
// depends on cau_pkg
module cau_div_stage #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int SHIFT      = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cau_pkg::cau_ctl_t                 ctl_in,
    input  logic [2*DATA_WIDTH-1:0]           den_in,
    input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_re_in,
    input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_im_in,
    input  logic [DATA_WIDTH-1:0]             q_re_in,
    input  logic [DATA_WIDTH-1:0]             q_im_in,
    input  logic [DATA_WIDTH-1:0]             pre_re_in,
    input  logic [DATA_WIDTH-1:0]             pre_im_in,
    output cau_pkg::cau_ctl_t                 ctl_out,
    output logic [2*DATA_WIDTH-1:0]           den_out,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_re_out,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_im_out,
    output logic [DATA_WIDTH-1:0]             q_re_out,
    output logic [DATA_WIDTH-1:0]             q_im_out,
    output logic [DATA_WIDTH-1:0]             pre_re_out,
    output logic [DATA_WIDTH-1:0]             pre_im_out
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int NW = 2*W + FRAC_BITS;
    localparam int DW = 3*W + FRAC_BITS + 1;

    logic [DW-1:0] d_sh, diff_re, diff_im;
    logic          ge_re, ge_im;
    logic [W-1:0]  bit_mask;

    assign d_sh     = DW'(den_in) << SHIFT;
    assign ge_re    = DW'(rem_re_in) >= d_sh;
    assign ge_im    = DW'(rem_im_in) >= d_sh;
    assign diff_re  = DW'(rem_re_in) - d_sh;
    assign diff_im  = DW'(rem_im_in) - d_sh;
    assign bit_mask = W'(1) << SHIFT;

    cau_ctl_t ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        den_out    <= den_in;
        rem_re_out <= ge_re ? diff_re[NW-1:0] : rem_re_in;
        rem_im_out <= ge_im ? diff_im[NW-1:0] : rem_im_in;
        q_re_out   <= ge_re ? (q_re_in | bit_mask) : q_re_in;
        q_im_out   <= ge_im ? (q_im_in | bit_mask) : q_im_in;
        pre_re_out <= pre_re_in;
        pre_im_out <= pre_im_in;
    end

    assign ctl_out = ctl_reg;

endmodule

// ===== hdl/cau_checker.sv =====
// cau_checker: port-level checks of the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arithmetic_unit_core
module cau_checker #(
    parameter int LATENCY = 37
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input cau_pkg::cau_res_t result
);
    import cau_pkg::*;

    // each done must trace back to an accepted request; the reverse is not checked
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start & ~busy, LATENCY))
        else $error("result without matching request");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_DIVZ ||
                  result.status == ST_OVF))
        else $error("bad status code");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_DIVZ) |-> (result.res_real == '0 &&
                                                result.res_imag == '0 &&
                                                !result.is_equal))
        else $error("divide by zero result not cleared");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_equal) |-> (result.status == ST_OK &&
                                       result.res_real == '0 &&
                                       result.res_imag == '0))
        else $error("compare result carries data");

endmodule

bind complex_arithmetic_unit_core cau_checker #(.LATENCY(DATA_WIDTH + 5)) u_cau_checker (.*);
